### rtl/ruia_pkg.sv
`default_nettype none
package ruia_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam logic [31:0] RESET_SEED = 32'd1000000009;
  localparam logic [31:0] SCRAMBLE_MULT = 32'd1597334677;

  // request opcodes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_RELEASED  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // table port control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } tbl_ctrl_t;

  // table compare result for the entry read in the previous cycle
  typedef struct packed {
    logic cmp_vld;
    logic hit;
    logic free;
  } tbl_stat_t;

  // one xorshift32 step with shifts 13, 17, 5
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage
`default_nettype wire

### rtl/ruia_in_if.sv
`default_nettype none
interface ruia_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] release_id;

  modport source (output valid, output func, output release_id, input ready);
  modport sink   (input valid, input func, input release_id, output ready);
endinterface
`default_nettype wire

### rtl/ruia_out_if.sv
`default_nettype none
interface ruia_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] given_id;
  logic [1:0]  status;

  modport source (output valid, output given_id, output status, input ready);
  modport sink   (input valid, input given_id, input status, output ready);
endinterface
`default_nettype wire

### rtl/ruia_table.sv
`default_nettype none
module ruia_table #(
  parameter int unsigned Capacity = ruia_pkg::CAPACITY_DEF,
  parameter int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ruia_pkg::tbl_ctrl_t ctrl_i,
  input  wire logic [IdxW-1:0]    rd_idx_i,
  input  wire logic [IdxW-1:0]    wr_idx_i,
  input  wire logic [31:0]        wr_id_i,
  input  wire logic [31:0]        key_i,
  output ruia_pkg::tbl_stat_t     stat_o,
  output logic [IdxW-1:0]         cmp_idx_o
);
  import ruia_pkg::*;

  // entry layout: {valid, id}
  logic [32:0]     mem_q [Capacity];
  logic [32:0]     rd_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_idx_i] <= {ctrl_i.wr_valid, wr_id_i};
    end
    if (ctrl_i.rd_en) begin
      rd_q      <= mem_q[rd_idx_i];
      cmp_idx_q <= rd_idx_i;
    end
  end

  // track which read data is fresh
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= ctrl_i.rd_en;
    end
  end

  // compare the entry against the key
  always_comb begin
    stat_o.cmp_vld = cmp_vld_q;
    stat_o.hit     = cmp_vld_q && rd_q[32] && (rd_q[31:0] == key_i);
    stat_o.free    = cmp_vld_q && !rd_q[32];
  end

  assign cmp_idx_o = cmp_idx_q;

endmodule
`default_nettype wire

### rtl/random_unique_id_allocator_core.sv
// Random unique identifier allocator.
// in_i carries one request word: func selects allocate or release, release_id
// names the identifier to give back. out_o returns one result word per
// request: given_id (zero unless allocated) and status (allocated, released,
// not found, table full). seed_we_i/seed_wdata_i reload the generator; zero
// selects the default seed. Write the seed only while the block is idle.
// Every request but an allocate against a full table walks the held table
// through one memory read port, one entry a cycle. An allocate runs each
// candidate through xorshift step, multiply, table walk and decide; a
// candidate already held forces another pass from the xorshift step.
// An allocate against a full table answers without a table walk.
// One request is in flight at a time; in_i.ready is high only when idle.
// A result waits in the output register while the receiver stalls; the
// next request is still accepted and holds at its final step until the
// output register is free.
// After reset the table is cleared, one entry a cycle, before the first
// request is accepted; seed writes are taken meanwhile.
`default_nettype none
module random_unique_id_allocator_core #(
  parameter int unsigned CAPACITY = ruia_pkg::CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        seed_we_i,
  input  wire logic [31:0] seed_wdata_i,
  ruia_in_if.sink          in_i,
  ruia_out_if.source       out_o
);
  import ruia_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_GEN,
    S_MUL,
    S_SCAN,
    S_LAST,
    S_DECIDE
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] scan_q;
  logic [CntW-1:0] count_q;
  logic            func_q;
  logic [31:0]     key_q;
  logic [31:0]     gen_q;
  logic            full_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic            free_ok_q;
  logic [IdxW-1:0] free_idx_q;
  logic            out_vld_q;
  logic [31:0]     out_id_q;
  logic [1:0]      out_st_q;

  tbl_ctrl_t       tbl_ctrl;
  tbl_stat_t       tbl_stat;
  logic [IdxW-1:0] cmp_idx;
  logic [IdxW-1:0] wr_idx;
  logic            in_fire;
  logic            out_room;
  logic            retry;
  logic            finish;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_room   = !out_vld_q || out_o.ready;
  assign retry      = (state_q == S_DECIDE) && (func_q == FUNC_ALLOC) && !full_q && hit_q;
  assign finish     = (state_q == S_DECIDE) && !retry && out_room;

  // drive the table ports
  always_comb begin
    tbl_ctrl.rd_en    = (state_q == S_SCAN);
    tbl_ctrl.wr_en    = (state_q == S_CLEAR) ||
                        (finish && (func_q == FUNC_ALLOC) && !full_q) ||
                        (finish && (func_q == FUNC_RELEASE) && hit_q);
    tbl_ctrl.wr_valid = (state_q != S_CLEAR) && (func_q == FUNC_ALLOC);
    if (state_q == S_CLEAR) begin
      wr_idx = scan_q;
    end else if (func_q == FUNC_ALLOC) begin
      wr_idx = free_idx_q;
    end else begin
      wr_idx = hit_idx_q;
    end
  end

  ruia_table #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tbl_ctrl),
    .rd_idx_i  (scan_q),
    .wr_idx_i  (wr_idx),
    .wr_id_i   (key_q),
    .key_i     (key_q),
    .stat_o    (tbl_stat),
    .cmp_idx_o (cmp_idx)
  );

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      scan_q     <= '0;
      count_q    <= '0;
      func_q     <= FUNC_ALLOC;
      key_q      <= '0;
      gen_q      <= RESET_SEED;
      full_q     <= 1'b0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_ok_q  <= 1'b0;
      free_idx_q <= '0;
      out_vld_q  <= 1'b0;
      out_id_q   <= '0;
      out_st_q   <= ST_ALLOCATED;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_o.valid && out_o.ready && !finish) begin
        out_vld_q <= 1'b0;
      end

      // reload the generator on a seed write
      if (seed_we_i) begin
        gen_q <= (seed_wdata_i == '0) ? RESET_SEED : seed_wdata_i;
      end

      // collect hit and first free entry while walking the table
      if ((state_q == S_SCAN) || (state_q == S_LAST)) begin
        if (tbl_stat.hit) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx;
        end
        if (tbl_stat.free && !free_ok_q) begin
          free_ok_q  <= 1'b1;
          free_idx_q <= cmp_idx;
        end
      end

      unique case (state_q)
        S_CLEAR: begin
          if (scan_q == LastIdx) begin
            scan_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            func_q    <= in_i.func;
            key_q     <= in_i.release_id;
            full_q    <= 1'b0;
            hit_q     <= 1'b0;
            free_ok_q <= 1'b0;
            scan_q    <= '0;
            if (in_i.func == FUNC_RELEASE) begin
              state_q <= S_SCAN;
            end else if (count_q == FullCnt) begin
              full_q  <= 1'b1;
              state_q <= S_DECIDE;
            end else begin
              state_q <= S_GEN;
            end
          end
        end
        S_GEN: begin
          gen_q     <= xorshift32(gen_q);
          hit_q     <= 1'b0;
          free_ok_q <= 1'b0;
          scan_q    <= '0;
          state_q   <= S_MUL;
        end
        S_MUL: begin
          key_q   <= gen_q * SCRAMBLE_MULT;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_q == LastIdx) begin
            state_q <= S_LAST;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_LAST: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (retry) begin
            state_q <= S_GEN;
          end else if (out_room) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
            if (func_q == FUNC_RELEASE) begin
              out_id_q <= '0;
              if (hit_q) begin
                out_st_q <= ST_RELEASED;
                count_q  <= count_q - 1'b1;
              end else begin
                out_st_q <= ST_NOT_FOUND;
              end
            end else if (full_q) begin
              out_id_q <= '0;
              out_st_q <= ST_FULL;
            end else begin
              out_id_q <= key_q;
              out_st_q <= ST_ALLOCATED;
              count_q  <= count_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.given_id = out_id_q;
  assign out_o.status   = out_st_q;

endmodule
`default_nettype wire
